[rtl/ear_clipping_triangulator_unit_defines.svh]
// Assertion macros shared by the triangulator RTL.
// Needs aclk and aresetn in the scope where a macro is used.
`ifndef EAR_CLIPPING_TRIANGULATOR_UNIT_DEFINES_SVH
`define EAR_CLIPPING_TRIANGULATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define ECT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ECT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ect_pkg.sv]
// Shared types and constants of the ear-clipping triangulator.
// No dependencies.
package ect_pkg;

    localparam int DEF_MAX_VERTICES = 32;
    localparam int DEF_COORD_WIDTH  = 16;

    localparam int IN_W      = 16;
    localparam int CORNER_W  = 5;
    localparam int EPS_W     = 16;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_EPS   = 0;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    typedef enum logic [1:0] {
        ST_TRI   = 2'd0,
        ST_FEW   = 2'd1,
        ST_NOEAR = 2'd2,
        ST_OVF   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RING_HOLD = 2'd0,
        RING_LOAD = 2'd1,
        RING_ROT  = 2'd2,
        RING_POP  = 2'd3
    } ring_op_t;

    // position of the current head beat within one ring scan
    typedef struct packed {
        logic vld;
        logic first;
        logic second;
        logic third;
        logic point;
    } scan_tag_t;

endpackage

[rtl/ect_cell.sv]
// One slot of the vertex ring: index and coordinates of one vertex.
// Depends on ect_pkg.
module ect_cell import ect_pkg::*; #(
    parameter int POS  = 0,
    parameter bit DESC = 1'b0,
    parameter int DW   = 37,
    parameter int NW   = 6
) (
    input  logic          aclk,
    input  ring_op_t      op,
    input  logic [NW-1:0] ptr,
    input  logic [NW-1:0] nv,
    input  logic [DW-1:0] din,
    input  logic [DW-1:0] left,
    input  logic [DW-1:0] right,
    input  logic [DW-1:0] head,
    output logic [DW-1:0] q
);

    logic [DW-1:0] data_reg, data_next;

    always_comb begin
        data_next = data_reg;
        case (op)
            RING_LOAD: begin
                if (DESC) begin
                    // vertex 0 stays at the head, later ones push in behind it
                    if (ptr == '0) begin
                        if (POS == 0) data_next = din;
                    end else if (POS == 1) begin
                        data_next = din;
                    end else if (POS >= 2) begin
                        data_next = left;
                    end
                end else if (POS == 0 || int'(ptr) + 1 == POS) begin
                    data_next = din;
                end
            end
            RING_ROT: data_next = (int'(nv) - 1 == POS) ? head : right;
            RING_POP: data_next = right;
            default:  data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

[rtl/ect_ring.sv]
// Row of ect_cell slots wired as a rotating ring with the head at slot 0.
// Depends on ect_pkg and ect_cell.
module ect_ring import ect_pkg::*; #(
    parameter int N    = 32,
    parameter bit DESC = 1'b0,
    parameter int DW   = 37,
    parameter int NW   = 6
) (
    input  logic          aclk,
    input  ring_op_t      op,
    input  logic [NW-1:0] ptr,
    input  logic [NW-1:0] nv,
    input  logic [DW-1:0] din,
    output logic [DW-1:0] head
);

    logic [DW-1:0] cell_q [N];

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic [DW-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = cell_q[0];
        end else begin : g_mid_l
            assign left_d = cell_q[i-1];
        end
        if (i == N - 1) begin : g_last
            assign right_d = cell_q[i];
        end else begin : g_mid_r
            assign right_d = cell_q[i+1];
        end
        ect_cell #(.POS(i), .DESC(DESC), .DW(DW), .NW(NW)) u_cell (
            .aclk  (aclk),
            .op    (op),
            .ptr   (ptr),
            .nv    (nv),
            .din   (din),
            .left  (left_d),
            .right (right_d),
            .head  (cell_q[0]),
            .q     (cell_q[i])
        );
    end

    assign head = cell_q[0];

endmodule

[rtl/ect_cross.sv]
// Three-stage cross-product pipeline: convex test on the third beat of a scan,
// inside test on every later beat. Depends on ect_pkg and the defines header.
`include "ear_clipping_triangulator_unit_defines.svh"
module ect_cross import ect_pkg::*; #(
    parameter int CW = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_tag_t            tag,
    input  logic signed [CW-1:0] hx,
    input  logic signed [CW-1:0] hy,
    input  logic [EPS_W-1:0]     eps,
    output logic                 convex,
    output logic                 enclosed
);

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [CW-1:0] a_x_reg, a_y_reg, b_x_reg, b_y_reg, c_x_reg, c_y_reg;
    logic signed [DW-1:0] eab_x_reg, eab_y_reg, ebc_x_reg, ebc_y_reg, eca_x_reg, eca_y_reg;
    logic signed [DW-1:0] dqa_x_reg, dqa_y_reg, dqb_x_reg, dqb_y_reg, dqc_x_reg, dqc_y_reg;
    logic signed [PW-1:0] pab1_reg, pab2_reg, pbc1_reg, pbc2_reg, pca1_reg, pca2_reg;
    scan_tag_t            tag1_reg, tag2_reg;
    logic                 convex_reg, inside_reg;
    logic signed [XW-1:0] cr_ab, cr_bc, cr_ca, eps_x;
    logic                 ge_ab, ge_bc, ge_ca;

    // stage 1: latch corners, form edge and point differences
    always_ff @(posedge aclk) begin
        if (tag.vld && tag.first) begin
            a_x_reg <= hx;
            a_y_reg <= hy;
        end
        if (tag.vld && tag.second) begin
            b_x_reg   <= hx;
            b_y_reg   <= hy;
            eab_x_reg <= DW'(hx) - DW'(a_x_reg);
            eab_y_reg <= DW'(hy) - DW'(a_y_reg);
        end
        if (tag.vld && tag.third) begin
            c_x_reg   <= hx;
            c_y_reg   <= hy;
            ebc_x_reg <= DW'(hx) - DW'(b_x_reg);
            ebc_y_reg <= DW'(hy) - DW'(b_y_reg);
            eca_x_reg <= DW'(a_x_reg) - DW'(hx);
            eca_y_reg <= DW'(a_y_reg) - DW'(hy);
        end
        dqa_x_reg <= DW'(hx) - DW'(a_x_reg);
        dqa_y_reg <= DW'(hy) - DW'(a_y_reg);
        dqb_x_reg <= DW'(hx) - DW'(b_x_reg);
        dqb_y_reg <= DW'(hy) - DW'(b_y_reg);
        dqc_x_reg <= DW'(hx) - DW'(c_x_reg);
        dqc_y_reg <= DW'(hy) - DW'(c_y_reg);
    end

    // stage 2: products
    always_ff @(posedge aclk) begin
        pab1_reg <= eab_x_reg * dqa_y_reg;
        pab2_reg <= eab_y_reg * dqa_x_reg;
        pbc1_reg <= ebc_x_reg * dqb_y_reg;
        pbc2_reg <= ebc_y_reg * dqb_x_reg;
        pca1_reg <= eca_x_reg * dqc_y_reg;
        pca2_reg <= eca_y_reg * dqc_x_reg;
    end

    // stage 3: subtract, compare, accumulate flags
    assign eps_x = $signed({1'b0, (XW-1)'(eps)});
    assign cr_ab = XW'(pab1_reg) - XW'(pab2_reg);
    assign cr_bc = XW'(pbc1_reg) - XW'(pbc2_reg);
    assign cr_ca = XW'(pca1_reg) - XW'(pca2_reg);
    assign ge_ab = (cr_ab >= eps_x);
    assign ge_bc = (cr_bc >= eps_x);
    assign ge_ca = (cr_ca >= eps_x);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg   <= '0;
            tag2_reg   <= '0;
            convex_reg <= 1'b0;
            inside_reg <= 1'b0;
        end else begin
            tag1_reg <= tag;
            tag2_reg <= tag1_reg;
            if (tag.vld && tag.first) begin
                convex_reg <= 1'b0;
                inside_reg <= 1'b0;
            end else if (tag2_reg.vld) begin
                if (tag2_reg.third) convex_reg <= ge_ab;
                if (tag2_reg.point && ge_ab && ge_bc && ge_ca) inside_reg <= 1'b1;
            end
        end
    end

    assign convex   = convex_reg;
    assign enclosed = inside_reg;

    `ECT_ASSERT_NEXT(a_flags_clear, tag.vld && tag.first, !inside_reg && !convex_reg, "flags not cleared at scan start")
    `ECT_ASSERT_NEXT(a_tag_flow, tag1_reg.vld, tag2_reg == $past(tag1_reg), "pipeline tag lost")
    `ECT_ASSERT_IMPL(a_tag_onehot, tag.vld, $onehot({tag.first, tag.second, tag.third, tag.point}), "scan tag not one-hot")

endmodule

[rtl/ear_clipping_triangulator_unit.sv]
// Top level of the ear-clipping triangulator: load control, area pass, ear search.
// Depends on ect_pkg, ect_ring, ect_cross and the defines header.
//
//  channel  | dir | handshake          | payload
//  s_       | in  | s_valid / s_ready  | x_coord, y_coord, last_vertex
//  m_       | out | m_valid / m_ready  | corner_a/b/c, positive_area, status, last_result
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (ear_epsilon)
//
// Loading accepts one vertex beat per cycle. After the last beat an area pass runs.
// Each ear try rotates the vertex ring once through the cross-product pipeline.
// A clipped ear adds an emit step and a pop step before the next try.
// s_ready is high only while loading; results wait in one output register.
// Reset is synchronous, active low; vertex storage is not reset.
`include "ear_clipping_triangulator_unit_defines.svh"
module ear_clipping_triangulator_unit import ect_pkg::*; #(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES,
    parameter int COORD_WIDTH  = DEF_COORD_WIDTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [IN_W-1:0]  s_x_coord,
    input  logic signed [IN_W-1:0]  s_y_coord,
    input  logic                    s_last_vertex,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CORNER_W-1:0]     m_corner_a,
    output logic [CORNER_W-1:0]     m_corner_b,
    output logic [CORNER_W-1:0]     m_corner_c,
    output logic                    m_positive_area,
    output logic [1:0]              m_status,
    output logic                    m_last_result,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready
);

    localparam int CW = COORD_WIDTH;
    localparam int IW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int TW = NW + 1;
    localparam int RW = IW + 2 * CW;
    localparam int AW = 2 * CW + 8;

    typedef enum logic [9:0] {
        S_LOAD   = 10'b0000000001,
        S_AREA   = 10'b0000000010,
        S_AWAIT  = 10'b0000000100,
        S_TRY    = 10'b0000001000,
        S_SCAN   = 10'b0000010000,
        S_DRAIN  = 10'b0000100000,
        S_DECIDE = 10'b0001000000,
        S_EMIT   = 10'b0010000000,
        S_POP    = 10'b0100000000,
        S_ERR    = 10'b1000000000
    } state_t;

    state_t         state_reg, state_next;
    logic [NW-1:0]  count_reg, count_next, count_after;
    logic           ovf_reg, ovf_next;
    logic [NW-1:0]  nv_reg, nv_next, p_reg, p_next;
    logic [TW-1:0]  tries_reg, tries_next, tries_init;
    logic           drain_reg, drain_next;
    logic           pos_reg, pos_next;
    status_t        err_reg, err_next;
    logic [EPS_W-1:0] eps_reg;

    logic           s_acc, cnt_full, out_free, ear, sel_a, rot_cur;
    logic           convex, enclosed;
    ring_op_t       op_a, op_d;
    logic [RW-1:0]  din, head_a, head_d, head;
    logic [IW-1:0]  h_idx;
    logic signed [CW-1:0] hx, hy;
    scan_tag_t      tag;

    logic [IW-1:0]  a_idx_reg, b_idx_reg, c_idx_reg;
    logic signed [CW-1:0]   prev_x_reg, prev_y_reg;
    logic signed [2*CW-1:0] ar_p1_reg, ar_p2_reg;
    logic           ar_vld_reg;
    logic signed [AW-1:0]   acc_reg;

    logic                m_valid_reg;
    logic [CORNER_W-1:0] ca_reg, cb_reg, cc_reg;
    logic                pos_out_reg, last_out_reg;
    status_t             st_out_reg;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= EPS_RESET;
        end else if (psel && penable && pwrite && paddr[PADDR_W-1:2] == 1'(REG_EPS)) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end
    assign prdata = (paddr[PADDR_W-1:2] == 1'(REG_EPS)) ? PDATA_W'(eps_reg) : '0;

    // ---------------- vertex rings ----------------
    assign s_ready     = (state_reg == S_LOAD);
    assign s_acc       = s_valid && s_ready;
    assign cnt_full    = (count_reg == NW'(MAX_VERTICES));
    assign count_after = cnt_full ? count_reg : count_reg + NW'(1);
    assign out_free    = !m_valid_reg || m_ready;
    assign ear         = convex && !enclosed;
    assign tries_init  = TW'({nv_reg, 1'b0});

    assign din = {IW'(count_reg), CW'($unsigned(s_x_coord)), CW'($unsigned(s_y_coord))};

    assign sel_a   = pos_reg || (state_reg == S_AREA);
    assign rot_cur = (state_reg == S_AREA && p_reg != nv_reg) || (state_reg == S_SCAN)
                   || (state_reg == S_DECIDE && !ear) || (state_reg == S_EMIT && out_free);

    always_comb begin
        op_a = RING_HOLD;
        op_d = RING_HOLD;
        if (s_acc && !cnt_full) begin
            op_a = RING_LOAD;
            op_d = RING_LOAD;
        end else if (rot_cur) begin
            if (sel_a) op_a = RING_ROT;
            else       op_d = RING_ROT;
        end else if (state_reg == S_POP) begin
            if (sel_a) op_a = RING_POP;
            else       op_d = RING_POP;
        end
    end

    ect_ring #(.N(MAX_VERTICES + 1), .DESC(1'b0), .DW(RW), .NW(NW)) u_ring_asc (
        .aclk (aclk), .op (op_a), .ptr (count_reg), .nv (nv_reg), .din (din), .head (head_a)
    );

    ect_ring #(.N(MAX_VERTICES), .DESC(1'b1), .DW(RW), .NW(NW)) u_ring_desc (
        .aclk (aclk), .op (op_d), .ptr (count_reg), .nv (nv_reg), .din (din), .head (head_d)
    );

    assign head  = sel_a ? head_a : head_d;
    assign h_idx = head[RW-1 -: IW];
    assign hx    = head[2*CW-1:CW];
    assign hy    = head[CW-1:0];

    // ---------------- ear test pipeline ----------------
    always_comb begin
        tag = '0;
        if (state_reg == S_SCAN) begin
            tag.vld    = 1'b1;
            tag.first  = (p_reg == NW'(0));
            tag.second = (p_reg == NW'(1));
            tag.third  = (p_reg == NW'(2));
            tag.point  = (p_reg >= NW'(3));
        end
    end

    ect_cross #(.CW(CW)) u_cross (
        .aclk (aclk), .aresetn (aresetn), .tag (tag), .hx (hx), .hy (hy),
        .eps (eps_reg), .convex (convex), .enclosed (enclosed)
    );

    always_ff @(posedge aclk) begin
        if (tag.first)  a_idx_reg <= h_idx;
        if (tag.second) b_idx_reg <= h_idx;
        if (tag.third)  c_idx_reg <= h_idx;
    end

    // ---------------- shoelace area ----------------
    always_ff @(posedge aclk) begin
        prev_x_reg <= hx;
        prev_y_reg <= hy;
        ar_p1_reg  <= prev_x_reg * hy;
        ar_p2_reg  <= hx * prev_y_reg;
        if (state_reg == S_LOAD) acc_reg <= '0;
        else if (ar_vld_reg)     acc_reg <= acc_reg + AW'(ar_p1_reg) - AW'(ar_p2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) ar_vld_reg <= 1'b0;
        else          ar_vld_reg <= (state_reg == S_AREA) && (p_reg != NW'(0));
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        nv_next    = nv_reg;
        p_next     = p_reg;
        tries_next = tries_reg;
        drain_next = drain_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        case (state_reg)
            S_LOAD: begin
                if (s_acc) begin
                    count_next = count_after;
                    if (cnt_full) ovf_next = 1'b1;
                    if (s_last_vertex) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        nv_next    = count_after;
                        p_next     = '0;
                        pos_next   = 1'b0;
                        if (ovf_reg || cnt_full) begin
                            err_next   = ST_OVF;
                            state_next = S_ERR;
                        end else if (count_after < NW'(3)) begin
                            err_next   = ST_FEW;
                            state_next = S_ERR;
                        end else begin
                            state_next = S_AREA;
                        end
                    end
                end
            end
            S_AREA: begin
                p_next = p_reg + NW'(1);
                if (p_reg == nv_reg) begin
                    drain_next = 1'b0;
                    state_next = S_AWAIT;
                end
            end
            S_AWAIT: begin
                drain_next = 1'b1;
                if (drain_reg) begin
                    pos_next   = !acc_reg[AW-1] && (acc_reg != '0);
                    tries_next = tries_init;
                    state_next = S_TRY;
                end
            end
            S_TRY: begin
                if (tries_reg == '0) begin
                    err_next   = ST_NOEAR;
                    state_next = S_ERR;
                end else begin
                    tries_next = tries_reg - TW'(1);
                    p_next     = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                p_next = p_reg + NW'(1);
                if (p_reg == nv_reg - NW'(1)) begin
                    drain_next = 1'b0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                drain_next = 1'b1;
                if (drain_reg) state_next = S_DECIDE;
            end
            S_DECIDE: state_next = ear ? S_EMIT : S_TRY;
            S_EMIT: begin
                if (out_free) state_next = S_POP;
            end
            S_POP: begin
                // drop the tip, which the previous rotation moved to the head
                nv_next    = nv_reg - NW'(1);
                tries_next = tries_init - TW'(2);
                state_next = (nv_reg == NW'(3)) ? S_LOAD : S_TRY;
            end
            S_ERR: begin
                if (out_free) state_next = S_LOAD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            nv_reg    <= '0;
            p_reg     <= '0;
            tries_reg <= '0;
            drain_reg <= 1'b0;
            pos_reg   <= 1'b0;
            err_reg   <= ST_TRI;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            nv_reg    <= nv_next;
            p_reg     <= p_next;
            tries_reg <= tries_next;
            drain_reg <= drain_next;
            pos_reg   <= pos_next;
            err_reg   <= err_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == S_EMIT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (state_reg == S_ERR && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT && out_free) begin
            ca_reg       <= CORNER_W'(a_idx_reg);
            cb_reg       <= CORNER_W'(b_idx_reg);
            cc_reg       <= CORNER_W'(c_idx_reg);
            pos_out_reg  <= pos_reg;
            st_out_reg   <= ST_TRI;
            last_out_reg <= (nv_reg == NW'(3));
        end else if (state_reg == S_ERR && out_free) begin
            ca_reg       <= '0;
            cb_reg       <= '0;
            cc_reg       <= '0;
            pos_out_reg  <= (err_reg == ST_NOEAR) ? pos_reg : 1'b0;
            st_out_reg   <= err_reg;
            last_out_reg <= 1'b1;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_corner_a      = ca_reg;
    assign m_corner_b      = cb_reg;
    assign m_corner_c      = cc_reg;
    assign m_positive_area = pos_out_reg;
    assign m_status        = st_out_reg;
    assign m_last_result   = last_out_reg;

    `ECT_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= NW'(MAX_VERTICES), "vertex count past capacity")
    `ECT_ASSERT_IMPL(a_tries_bound, state_reg == S_TRY, tries_reg <= tries_init, "try budget above 2*nv")
    `ECT_ASSERT_IMPL(a_emit_src, $rose(m_valid_reg), $past(state_reg) == S_EMIT || $past(state_reg) == S_ERR, "result beat from wrong state")
    `ECT_ASSERT_IMPL(a_nv_floor, state_reg == S_SCAN, nv_reg >= NW'(3), "scan with fewer than three vertices")

endmodule

[tb/ear_clipping_triangulator_unit_tb.sv]
// Self-checking testbench for ear_clipping_triangulator_unit.
// Drives vertex beats and epsilon writes, predicts triangles in a scoreboard class.
// Depends on ect_pkg and the RTL of the triangulator.
`timescale 1ns / 100ps

module ear_clipping_triangulator_unit_tb;
    import ect_pkg::*;

    localparam int NV_MAX     = DEF_MAX_VERTICES;
    localparam int IDLE_LIMIT = 40000;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
        logic                pos;
        status_t             st;
        logic                last;
    } tri_res_t;

    class tri_scoreboard;
        shortint  vx[NV_MAX];
        shortint  vy[NV_MAX];
        int       ord[NV_MAX];
        int       nvert;
        bit       ovf;
        int       eps;
        tri_res_t pending_tris[$];
        int       errors;
        int       polygons;
        int       checked;

        function new();
            nvert = 0;
            ovf = 0;
            eps = EPS_RESET;
            errors = 0;
            polygons = 0;
            checked = 0;
        endfunction

        function void fail(string what);
            errors++;
            if (errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
        endfunction

        function void push(int a, int b, int c, bit pos, status_t st, bit last);
            tri_res_t r;
            r.a = a[CORNER_W-1:0];
            r.b = b[CORNER_W-1:0];
            r.c = c[CORNER_W-1:0];
            r.pos = pos;
            r.st = st;
            r.last = last;
            pending_tris.insert(pending_tris.size(), r);
        endfunction

        // (b - a) x (c - a)
        function longint cross3(int a, int b, int c);
            longint bx, by, cx, cy;
            bx = longint'(vx[b]) - longint'(vx[a]);
            by = longint'(vy[b]) - longint'(vy[a]);
            cx = longint'(vx[c]) - longint'(vx[a]);
            cy = longint'(vy[c]) - longint'(vy[a]);
            return bx * cy - by * cx;
        endfunction

        function bit ear_ok(int u, int v, int w, int nv);
            int a, b, c, q;
            a = ord[u];
            b = ord[v];
            c = ord[w];
            if (cross3(a, b, c) < longint'(eps)) return 0;
            for (int p = 0; p < nv; p++) begin
                if (p == u || p == v || p == w) continue;
                q = ord[p];
                if (cross3(b, c, q) >= eps && cross3(c, a, q) >= eps &&
                    cross3(a, b, q) >= eps) return 0;
            end
            return 1;
        endfunction

        function void triangulate();
            int n, nv, u, v, w, tries, pi;
            longint area2;
            bit pos;
            n = nvert;
            nv = n;
            area2 = 0;
            if (n < 3) begin
                push(0, 0, 0, 0, ST_FEW, 1);
                return;
            end
            for (int i = 0; i < n; i++) begin
                pi = (i == 0) ? n - 1 : i - 1;
                area2 += longint'(vx[pi]) * vy[i] - longint'(vx[i]) * vy[pi];
            end
            pos = area2 > 0;
            for (int i = 0; i < n; i++) ord[i] = pos ? i : n - 1 - i;
            tries = 2 * nv;
            v = nv - 1;
            while (nv > 2) begin
                if (tries == 0) begin
                    push(0, 0, 0, pos, ST_NOEAR, 1);
                    return;
                end
                tries--;
                u = v;
                if (u >= nv) u = 0;
                v = u + 1;
                if (v >= nv) v = 0;
                w = v + 1;
                if (w >= nv) w = 0;
                if (ear_ok(u, v, w, nv)) begin
                    push(ord[u], ord[v], ord[w], pos, ST_TRI, nv == 3);
                    for (int s = v; s + 1 < nv; s++) ord[s] = ord[s + 1];
                    nv--;
                    tries = 2 * nv;
                end
            end
        endfunction

        function void note_input(shortint x, shortint y, bit last);
            if (nvert < NV_MAX) begin
                vx[nvert] = x;
                vy[nvert] = y;
                nvert++;
            end else begin
                ovf = 1;
            end
            if (!last) return;
            polygons++;
            if (ovf) push(0, 0, 0, 0, ST_OVF, 1);
            else triangulate();
            nvert = 0;
            ovf = 0;
        endfunction

        function void check_result(tri_res_t got);
            tri_res_t want;
            checked++;
            if (pending_tris.size() == 0) begin
                fail($sformatf("unexpected result %0d/%0d/%0d st=%0d",
                               got.a, got.b, got.c, got.st));
                return;
            end
            want = pending_tris[0];
            pending_tris.delete(0);
            if (got !== want)
                fail($sformatf({"result mismatch: exp a=%0d b=%0d c=%0d pos=%0b st=%0d ",
                                "last=%0b, got a=%0d b=%0d c=%0d pos=%0b st=%0d last=%0b"},
                               want.a, want.b, want.c, want.pos, want.st, want.last,
                               got.a, got.b, got.c, got.pos, got.st, got.last));
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic signed [IN_W-1:0] s_x_coord;
    logic signed [IN_W-1:0] s_y_coord;
    logic                   s_last_vertex;
    logic                   m_valid;
    logic                   m_ready;
    logic [CORNER_W-1:0]    m_corner_a;
    logic [CORNER_W-1:0]    m_corner_b;
    logic [CORNER_W-1:0]    m_corner_c;
    logic                   m_positive_area;
    logic [1:0]             m_status;
    logic                   m_last_result;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    tri_scoreboard sb = new();
    shortint pt_x[$];
    shortint pt_y[$];
    bit      quiet;
    bit      hold_req;
    int      idle_cnt;
    int      beats_sent;

    ear_clipping_triangulator_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_x_coord(s_x_coord), .s_y_coord(s_y_coord), .s_last_vertex(s_last_vertex),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_corner_a(m_corner_a), .m_corner_b(m_corner_b), .m_corner_c(m_corner_c),
        .m_positive_area(m_positive_area), .m_status(m_status),
        .m_last_result(m_last_result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // monitor both channels and run the watchdog
    always @(posedge aclk) begin
        tri_res_t got;
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_x_coord, s_y_coord, s_last_vertex);
            if (m_valid && m_ready) begin
                got.a = m_corner_a;
                got.b = m_corner_b;
                got.c = m_corner_c;
                got.pos = m_positive_area;
                got.st = status_t'(m_status);
                got.last = m_last_result;
                sb.check_result(got);
            end
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cnt = 0;
        else idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic set_epsilon(input int value);
        logic [PDATA_W-1:0] rd;
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= PADDR_W'(REG_EPS * 4);
        // upper bits are junk on purpose, the block must drop them
        pwdata <= {16'($urandom), 16'(value)};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        sb.eps = value & 16'hFFFF;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (rd[EPS_W-1:0] !== EPS_W'(value))
            sb.fail($sformatf("epsilon readback exp %0d got %0d", value, rd[EPS_W-1:0]));
    endtask

    task automatic send_vertex(input shortint x, input shortint y, input bit last);
        s_x_coord <= x;
        s_y_coord <= y;
        s_last_vertex <= last;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic add_pt(input int x, input int y);
        pt_x.insert(pt_x.size(), shortint'(x));
        pt_y.insert(pt_y.size(), shortint'(y));
    endtask

    task automatic flush_polygon();
        for (int i = 0; i < pt_x.size(); i++)
            send_vertex(pt_x[i], pt_y[i], i == pt_x.size() - 1);
        pt_x.delete();
        pt_y.delete();
    endtask

    // star-shaped polygon: sorted points along a square outline, radius jittered
    task automatic add_star(input int k);
        int scale, span, t, side, off, px, py, sc;
        bit rev;
        scale = $urandom_range(200, 32767);
        span = 4096 / k;
        t = $urandom_range(0, span - 1);
        rev = $urandom_range(0, 1);
        for (int i = 0; i < k; i++) begin
            side = t / 1024;
            off = t % 1024;
            case (side)
                0: begin px = -1024 + 2 * off; py = -1024; end
                1: begin px = 1024; py = -1024 + 2 * off; end
                2: begin px = 1024 - 2 * off; py = 1024; end
                default: begin px = -1024; py = 1024 - 2 * off; end
            endcase
            sc = scale * $urandom_range(16, 32) / 32;
            if (rev) begin
                pt_x.insert(0, shortint'(px * sc / 1024));
                pt_y.insert(0, shortint'(py * sc / 1024));
            end else begin
                add_pt(px * sc / 1024, py * sc / 1024);
            end
            t += $urandom_range(1, span);
        end
    endtask

    task automatic add_noise(input int k);
        for (int i = 0; i < k; i++) add_pt($urandom, $urandom);
    endtask

    task automatic drain();
        // the last beat is taken, drop valid so it is not offered again
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_tris.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
    endtask

    initial begin
        int eps_list[4];
        int phase_start, kind;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_x_coord <= '0;
        s_y_coord <= '0;
        s_last_vertex <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        quiet = 0;
        hold_req = 0;
        idle_cnt = 0;
        beats_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_epsilon(1);

        // single vertex, two vertices: too few
        add_pt(32767, -32768);
        flush_polygon();
        add_pt(-32768, 32767);
        add_pt(32767, 32767);
        flush_polygon();
        // collinear: no ear
        add_pt(0, 0); add_pt(100, 100); add_pt(200, 200);
        flush_polygon();
        // extreme triangle both windings
        add_pt(-32768, -32768); add_pt(32767, -32768); add_pt(0, 32767);
        flush_polygon();
        add_pt(0, 32767); add_pt(32767, -32768); add_pt(-32768, -32768);
        flush_polygon();
        // concave quad
        add_pt(0, 0); add_pt(1000, 500); add_pt(2000, 0); add_pt(1000, 2000);
        flush_polygon();
        // zero area
        add_pt(5, 5); add_pt(5, 5); add_pt(5, 5);
        flush_polygon();
        // reflex vertex blocking ears
        add_pt(0, 0); add_pt(4000, 0); add_pt(4000, 4000); add_pt(2000, 500);
        add_pt(0, 4000);
        flush_polygon();
        drain();

        eps_list[0] = 0;
        eps_list[1] = 65535;
        eps_list[2] = $urandom_range(2, 4000);
        eps_list[3] = 1;
        for (int ph = 0; ph < 4; ph++) begin
            set_epsilon(eps_list[ph]);
            phase_start = beats_sent;
            if (ph == 1) begin
                // stall results while a full polygon and more beats queue up
                hold_req = 1;
                add_star(NV_MAX);
                flush_polygon();
            end
            while (beats_sent - phase_start < 58) begin
                if (ph == 3 && beats_sent - phase_start > 25) quiet = 1;
                kind = $urandom_range(0, 19);
                if (kind == 0) add_noise($urandom_range(1, 8));
                else if (kind == 1) add_star(NV_MAX);
                else if (kind == 2) add_noise($urandom_range(NV_MAX + 1, NV_MAX + 3));
                else add_star($urandom_range(3, 10));
                flush_polygon();
            end
            drain();
        end
        s_valid <= 1'b0;
        repeat (200) @(posedge aclk);

        $display("tb: %0d polygons in %0d vertex beats, %0d results checked",
                 sb.polygons, beats_sent, sb.checked);
        $display("tb: epsilon values 1, 0, 65535, %0d; %0d mismatches",
                 eps_list[2], sb.errors);
        if (sb.errors == 0 && sb.pending_tris.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[ear_clipping_triangulator_unit.f]
+incdir+rtl
rtl/ect_pkg.sv
rtl/ect_cell.sv
rtl/ect_ring.sv
rtl/ect_cross.sv
rtl/ear_clipping_triangulator_unit.sv
tb/ear_clipping_triangulator_unit_tb.sv
